// ===== design/adwu_pkg.sv =====
// adwu_pkg: shared types, constants and helper functions for the adam weight update unit
// used by every module of the design; depends on nothing else

package adwu_pkg;

    // value format: signed Q4.28
    localparam int VALUE_W = 32;
    localparam int FRAC    = 28;
    localparam int WIDE_W  = 64;

    // derived widths
    localparam int MHAT_W  = 37;   // rounded mhat, kept wide
    localparam int MAG_W   = 36;   // magnitude of mhat
    localparam int PROD_W  = 52;   // learn_rate times magnitude
    localparam int VHAT_W  = 35;   // clamped vhat
    localparam int ROOT_W  = 32;   // integer square root of vhat scaled by 2^FRAC
    localparam int REM_W   = 33;   // square root partial remainder
    localparam int DEN_W   = 33;   // root plus epsilon
    localparam int Q_W     = 41;   // quotient bits kept below the step cap
    localparam int HI_W    = WIDE_W - Q_W;

    // pipeline depths
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = Q_W;

    // epsilon 1e-8 in Q4.28, rounded to nearest
    localparam logic [DEN_W-1:0] EPS = 33'd3;

    // largest step magnitude, 2^40
    localparam logic [Q_W-1:0] STEP_CAP = 41'd1 << 40;

    // configuration register reset values
    localparam logic [16:0] GRAD_SCALE_RST  = 17'd65536;
    localparam logic [15:0] BETA_FIRST_RST  = 16'd52429;
    localparam logic [15:0] BETA_SECOND_RST = 16'd58327;
    localparam logic [19:0] FIRST_CORR_RST  = 20'd327680;
    localparam logic [19:0] SECOND_CORR_RST = 20'd595782;
    localparam logic [15:0] LEARN_RATE_RST  = 16'd6554;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_GRAD_SCALE  = 3'd0,
        CFG_BETA_FIRST  = 3'd1,
        CFG_BETA_SECOND = 3'd2,
        CFG_FIRST_CORR  = 3'd3,
        CFG_SECOND_CORR = 3'd4,
        CFG_LEARN_RATE  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [16:0] grad_scale;
        logic [15:0] beta_first;
        logic [15:0] beta_second;
        logic [19:0] first_correction;
        logic [19:0] second_correction;
        logic [15:0] learn_rate;
    } cfg_t;

    // values that ride along to the final stage
    typedef struct packed {
        logic [VALUE_W-1:0] w;
        logic [VALUE_W-1:0] mm;
        logic [VALUE_W-1:0] vv;
        logic               flag;
        logic               neg;
    } carry_t;

    typedef struct packed {
        logic                valid;
        carry_t              c;
        logic [WIDE_W-1:0]   num;
        logic [VHAT_W-1:0]   vhat;
    } front_t;

    typedef struct packed {
        logic                valid;
        carry_t              c;
        logic [WIDE_W-1:0]   num;
        logic [ROOT_W-1:0]   root;
    } root_t;

    typedef struct packed {
        logic                valid;
        carry_t              c;
        logic                over;
        logic [Q_W-1:0]      q;
    } quot_t;

    // round to nearest by 2^16
    function automatic logic signed [WIDE_W-1:0] rnd16(input logic signed [WIDE_W-1:0] x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    // round to nearest by 2^FRAC
    function automatic logic signed [WIDE_W-1:0] rnd_frac(input logic signed [WIDE_W-1:0] x);
        return (x + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    // clip to the value range
    function automatic logic [VALUE_W-1:0] sat_val(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = (64'sd1 <<< (VALUE_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi)
            return hi[VALUE_W-1:0];
        else if (x < lo)
            return lo[VALUE_W-1:0];
        else
            return x[VALUE_W-1:0];
    endfunction

    // set when the value range clips
    function automatic logic sat_hit(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = (64'sd1 <<< (VALUE_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        return (x > hi) || (x < lo);
    endfunction

endpackage

// ===== design/adwu_front.sv =====
// adwu_front: eight-stage multiply and round front end (clip, moments, bias correction)
// depends on adwu_pkg

module adwu_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  adwu_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    input  logic [adwu_pkg::VALUE_W-1:0]  weight_in,
    input  logic [adwu_pkg::VALUE_W-1:0]  gradient,
    input  logic [adwu_pkg::VALUE_W-1:0]  moment_one_in,
    input  logic [adwu_pkg::VALUE_W-1:0]  moment_two_in,
    output adwu_pkg::front_t              front
);

    logic [7:0] vld_reg;

    // stage 1
    logic [adwu_pkg::VALUE_W-1:0] s1_w_reg, s1_m_reg, s1_v_reg;
    logic signed [adwu_pkg::WIDE_W-1:0] s1_pg_reg, s1_pg_next;
    // stage 2
    logic [adwu_pkg::VALUE_W-1:0] s2_w_reg, s2_m_reg, s2_v_reg, s2_g_reg, s2_g_next;
    logic s2_flag_reg, s2_flag_next;
    // stage 3
    logic [adwu_pkg::VALUE_W-1:0] s3_w_reg;
    logic signed [adwu_pkg::WIDE_W-1:0] s3_sqp_reg, s3_ma_reg, s3_mb_reg, s3_va_reg;
    logic signed [adwu_pkg::WIDE_W-1:0] s3_sqp_next, s3_ma_next, s3_mb_next, s3_va_next;
    logic s3_flag_reg;
    // stage 4
    logic [adwu_pkg::VALUE_W-1:0] s4_w_reg, s4_sq_reg, s4_mm_reg, s4_sq_next, s4_mm_next;
    logic signed [adwu_pkg::WIDE_W-1:0] s4_va_reg;
    logic s4_flag_reg, s4_flag_next;
    // stage 5
    logic [adwu_pkg::VALUE_W-1:0] s5_w_reg, s5_mm_reg;
    logic signed [adwu_pkg::WIDE_W-1:0] s5_va_reg, s5_vb_reg, s5_mhp_reg, s5_vb_next, s5_mhp_next;
    logic s5_flag_reg;
    // stage 6
    logic [adwu_pkg::VALUE_W-1:0] s6_w_reg, s6_mm_reg, s6_vv_reg, s6_vv_next;
    logic signed [adwu_pkg::WIDE_W-1:0] s6_mhat_full, s6_vsum;
    logic [adwu_pkg::MHAT_W-1:0] s6_mhat_reg;
    logic s6_flag_reg, s6_flag_next;
    // stage 7
    logic [adwu_pkg::VALUE_W-1:0] s7_w_reg, s7_mm_reg, s7_vv_reg;
    logic [adwu_pkg::MHAT_W-1:0] s7_mag_full;
    logic [adwu_pkg::PROD_W-1:0] s7_np_reg, s7_np_next;
    logic signed [adwu_pkg::WIDE_W-1:0] s7_vhp_reg, s7_vhp_next;
    logic s7_flag_reg, s7_neg_reg;
    // stage 8
    logic signed [adwu_pkg::WIDE_W-1:0] s8_vh;
    adwu_pkg::front_t s8_reg, s8_next;

    logic signed [17:0] omb1, omb2;

    // one minus each decay rate, Q1.16
    assign omb1 = 18'sd65536 - $signed({2'b00, cfg.beta_first});
    assign omb2 = 18'sd65536 - $signed({2'b00, cfg.beta_second});

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[6:0], in_valid};
    end

    // stage 1: gradient times clip factor
    assign s1_pg_next = $signed(gradient) * $signed({1'b0, cfg.grad_scale});

    // stage 2: round and clip the scaled gradient
    assign s2_g_next    = adwu_pkg::sat_val(adwu_pkg::rnd16(s1_pg_reg));
    assign s2_flag_next = adwu_pkg::sat_hit(adwu_pkg::rnd16(s1_pg_reg));

    // stage 3: gradient square and moment products
    assign s3_sqp_next = $signed(s2_g_reg) * $signed(s2_g_reg);
    assign s3_ma_next  = $signed({1'b0, cfg.beta_first}) * $signed(s2_m_reg);
    assign s3_mb_next  = omb1 * $signed(s2_g_reg);
    assign s3_va_next  = $signed({1'b0, cfg.beta_second}) * $signed(s2_v_reg);

    // stage 4: square and first moment
    always_comb
    begin
        s4_sq_next   = adwu_pkg::sat_val(adwu_pkg::rnd_frac(s3_sqp_reg));
        s4_mm_next   = adwu_pkg::sat_val(adwu_pkg::rnd16(s3_ma_reg + s3_mb_reg));
        s4_flag_next = s3_flag_reg
                     | adwu_pkg::sat_hit(adwu_pkg::rnd_frac(s3_sqp_reg))
                     | adwu_pkg::sat_hit(adwu_pkg::rnd16(s3_ma_reg + s3_mb_reg));
    end

    // stage 5: bias correction product and second moment product
    assign s5_mhp_next = $signed(s4_mm_reg) * $signed({1'b0, cfg.first_correction});
    assign s5_vb_next  = omb2 * $signed(s4_sq_reg);

    // stage 6: mhat and second moment
    always_comb
    begin
        s6_mhat_full = adwu_pkg::rnd16(s5_mhp_reg);
        s6_vsum      = adwu_pkg::rnd16(s5_va_reg + s5_vb_reg);
        s6_vv_next   = adwu_pkg::sat_val(s6_vsum);
        s6_flag_next = s5_flag_reg | adwu_pkg::sat_hit(s6_vsum);
    end

    // stage 7: numerator product and vhat product
    always_comb
    begin
        s7_mag_full = s6_mhat_reg[adwu_pkg::MHAT_W-1] ? (~s6_mhat_reg + 1'b1) : s6_mhat_reg;
        s7_np_next  = adwu_pkg::PROD_W'(cfg.learn_rate * s7_mag_full[adwu_pkg::MAG_W-1:0]);
        s7_vhp_next = $signed(s6_vv_reg) * $signed({1'b0, cfg.second_correction});
    end

    // stage 8: clamp vhat and align numerator
    always_comb
    begin
        s8_vh            = adwu_pkg::rnd16(s7_vhp_reg);
        s8_next.valid    = vld_reg[6];
        s8_next.c.w      = s7_w_reg;
        s8_next.c.mm     = s7_mm_reg;
        s8_next.c.vv     = s7_vv_reg;
        s8_next.c.flag   = s7_flag_reg;
        s8_next.c.neg    = s7_neg_reg;
        s8_next.num      = {s7_np_reg, 12'b0};
        s8_next.vhat     = s8_vh[adwu_pkg::WIDE_W-1] ? '0 : s8_vh[adwu_pkg::VHAT_W-1:0];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_w_reg    <= weight_in;
            s1_m_reg    <= moment_one_in;
            s1_v_reg    <= moment_two_in;
            s1_pg_reg   <= s1_pg_next;

            s2_w_reg    <= s1_w_reg;
            s2_m_reg    <= s1_m_reg;
            s2_v_reg    <= s1_v_reg;
            s2_g_reg    <= s2_g_next;
            s2_flag_reg <= s2_flag_next;

            s3_w_reg    <= s2_w_reg;
            s3_sqp_reg  <= s3_sqp_next;
            s3_ma_reg   <= s3_ma_next;
            s3_mb_reg   <= s3_mb_next;
            s3_va_reg   <= s3_va_next;
            s3_flag_reg <= s2_flag_reg;

            s4_w_reg    <= s3_w_reg;
            s4_sq_reg   <= s4_sq_next;
            s4_mm_reg   <= s4_mm_next;
            s4_va_reg   <= s3_va_reg;
            s4_flag_reg <= s4_flag_next;

            s5_w_reg    <= s4_w_reg;
            s5_mm_reg   <= s4_mm_reg;
            s5_va_reg   <= s4_va_reg;
            s5_vb_reg   <= s5_vb_next;
            s5_mhp_reg  <= s5_mhp_next;
            s5_flag_reg <= s4_flag_reg;

            s6_w_reg    <= s5_w_reg;
            s6_mm_reg   <= s5_mm_reg;
            s6_vv_reg   <= s6_vv_next;
            s6_mhat_reg <= s6_mhat_full[adwu_pkg::MHAT_W-1:0];
            s6_flag_reg <= s6_flag_next;

            s7_w_reg    <= s6_w_reg;
            s7_mm_reg   <= s6_mm_reg;
            s7_vv_reg   <= s6_vv_reg;
            s7_np_reg   <= s7_np_next;
            s7_vhp_reg  <= s7_vhp_next;
            s7_flag_reg <= s6_flag_reg;
            s7_neg_reg  <= s6_mhat_reg[adwu_pkg::MHAT_W-1];

            s8_reg      <= s8_next;
        end
    end

    always_comb
    begin
        front       = s8_reg;
        front.valid = vld_reg[7];
    end

endmodule

// ===== design/adwu_sqrt.sv =====
// adwu_sqrt: pipelined digit-by-digit integer square root, one root bit per stage
// depends on adwu_pkg

module adwu_sqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  adwu_pkg::front_t  front,
    output adwu_pkg::root_t   root
);

    typedef struct packed {
        adwu_pkg::carry_t                c;
        logic [adwu_pkg::WIDE_W-1:0]     num;
        logic [adwu_pkg::WIDE_W-1:0]     xs;
        logic [adwu_pkg::REM_W-1:0]      rem;
        logic [adwu_pkg::ROOT_W-1:0]     r;
    } sq_st_t;

    logic   [adwu_pkg::SQRT_STEPS-1:0] vld_reg;
    sq_st_t st_reg  [adwu_pkg::SQRT_STEPS];
    sq_st_t st_next [adwu_pkg::SQRT_STEPS];
    sq_st_t st_in   [adwu_pkg::SQRT_STEPS];
    sq_st_t first;

    // radicand is vhat scaled by 2^FRAC
    always_comb
    begin
        first.c   = front.c;
        first.num = front.num;
        first.xs  = {1'b0, front.vhat, {adwu_pkg::FRAC{1'b0}}};
        first.rem = '0;
        first.r   = '0;
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[adwu_pkg::SQRT_STEPS-2:0], front.valid};
    end

    genvar i;
    generate
        for (i = 0; i < adwu_pkg::SQRT_STEPS; i++)
        begin : g_step
            logic [adwu_pkg::REM_W+1:0] cur;
            logic [adwu_pkg::REM_W+1:0] trial;

            if (i == 0)
            begin : g_first
                assign st_in[i] = first;
            end
            else
            begin : g_rest
                assign st_in[i] = st_reg[i-1];
            end

            // bring down two radicand bits and try the next root bit
            always_comb
            begin
                cur        = {st_in[i].rem, st_in[i].xs[adwu_pkg::WIDE_W-1 -: 2]};
                trial      = {1'b0, st_in[i].r, 2'b01};
                st_next[i] = st_in[i];
                st_next[i].xs = {st_in[i].xs[adwu_pkg::WIDE_W-3:0], 2'b00};
                if (cur >= trial)
                begin
                    st_next[i].rem = adwu_pkg::REM_W'(cur - trial);
                    st_next[i].r   = {st_in[i].r[adwu_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    st_next[i].rem = cur[adwu_pkg::REM_W-1:0];
                    st_next[i].r   = {st_in[i].r[adwu_pkg::ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    st_reg[i] <= st_next[i];
            end
        end
    endgenerate

    assign root.valid = vld_reg[adwu_pkg::SQRT_STEPS-1];
    assign root.c     = st_reg[adwu_pkg::SQRT_STEPS-1].c;
    assign root.num   = st_reg[adwu_pkg::SQRT_STEPS-1].num;
    assign root.root  = st_reg[adwu_pkg::SQRT_STEPS-1].r;

endmodule

// ===== design/adwu_div.sv =====
// adwu_div: pipelined rounded restoring divider for the weight step, one quotient bit per stage
// depends on adwu_pkg

module adwu_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  adwu_pkg::root_t   root,
    output adwu_pkg::quot_t   quot
);

    typedef struct packed {
        adwu_pkg::carry_t                c;
        logic [adwu_pkg::DEN_W-1:0]      den;
        logic [adwu_pkg::WIDE_W-1:0]     dvd;
    } prep_t;

    typedef struct packed {
        adwu_pkg::carry_t                c;
        logic                            over;
        logic [adwu_pkg::DEN_W-1:0]      den;
        logic [adwu_pkg::Q_W-1:0]        dl;
        logic [adwu_pkg::DEN_W-1:0]      rem;
        logic [adwu_pkg::Q_W-1:0]        q;
    } dv_st_t;

    logic [1:0]                       pre_vld_reg;
    logic [adwu_pkg::DIV_STEPS-1:0]   vld_reg;
    prep_t  prep_reg, prep_next;
    dv_st_t init_reg, init_next;
    dv_st_t st_reg  [adwu_pkg::DIV_STEPS];
    dv_st_t st_next [adwu_pkg::DIV_STEPS];
    dv_st_t st_in   [adwu_pkg::DIV_STEPS];
    logic [adwu_pkg::DEN_W-1:0] den_sum;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= '0;
            vld_reg     <= '0;
        end
        else if (adv)
        begin
            pre_vld_reg <= {pre_vld_reg[0], root.valid};
            vld_reg     <= {vld_reg[adwu_pkg::DIV_STEPS-2:0], pre_vld_reg[1]};
        end
    end

    // denominator and dividend with half the denominator added for rounding
    always_comb
    begin
        den_sum       = adwu_pkg::DEN_W'(root.root) + adwu_pkg::EPS;
        prep_next.c   = root.c;
        prep_next.den = den_sum;
        prep_next.dvd = root.num + adwu_pkg::WIDE_W'(den_sum >> 1);
    end

    // quotient of 2^41 or more is capped anyway
    always_comb
    begin
        init_next.c    = prep_reg.c;
        init_next.den  = prep_reg.den;
        init_next.over = adwu_pkg::DEN_W'(prep_reg.dvd[adwu_pkg::WIDE_W-1 -: adwu_pkg::HI_W])
                         >= prep_reg.den;
        init_next.rem  = adwu_pkg::DEN_W'(prep_reg.dvd[adwu_pkg::WIDE_W-1 -: adwu_pkg::HI_W]);
        init_next.dl   = prep_reg.dvd[adwu_pkg::Q_W-1:0];
        init_next.q    = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prep_reg <= prep_next;
            init_reg <= init_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < adwu_pkg::DIV_STEPS; i++)
        begin : g_step
            logic [adwu_pkg::DEN_W:0] cur;

            if (i == 0)
            begin : g_first
                assign st_in[i] = init_reg;
            end
            else
            begin : g_rest
                assign st_in[i] = st_reg[i-1];
            end

            // bring down one dividend bit and subtract if it fits
            always_comb
            begin
                cur        = {st_in[i].rem, st_in[i].dl[adwu_pkg::Q_W-1]};
                st_next[i] = st_in[i];
                st_next[i].dl = {st_in[i].dl[adwu_pkg::Q_W-2:0], 1'b0};
                if (cur >= {1'b0, st_in[i].den})
                begin
                    st_next[i].rem = adwu_pkg::DEN_W'(cur - {1'b0, st_in[i].den});
                    st_next[i].q   = {st_in[i].q[adwu_pkg::Q_W-2:0], 1'b1};
                end
                else
                begin
                    st_next[i].rem = cur[adwu_pkg::DEN_W-1:0];
                    st_next[i].q   = {st_in[i].q[adwu_pkg::Q_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    st_reg[i] <= st_next[i];
            end
        end
    endgenerate

    assign quot.valid = vld_reg[adwu_pkg::DIV_STEPS-1];
    assign quot.c     = st_reg[adwu_pkg::DIV_STEPS-1].c;
    assign quot.over  = st_reg[adwu_pkg::DIV_STEPS-1].over;
    assign quot.q     = st_reg[adwu_pkg::DIV_STEPS-1].q;

endmodule

// ===== design/adam_weight_update_unit.sv =====
// adam_weight_update_unit: Adam step for one weight per transaction, signed Q4.28 values
// pipeline of 8 multiply stages, 32 square root stages, 43 divider stages and an output register
// throughput one transaction per cycle; the whole pipeline advances together and holds on out_stall
// reset clears all valid bits and loads the configuration registers with their defaults
// depends on adwu_pkg, adwu_front, adwu_sqrt, adwu_div

module adam_weight_update_unit (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] weight_in,
    input  logic [31:0] gradient,
    input  logic [31:0] moment_one_in,
    input  logic [31:0] moment_two_in,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] weight_out,
    output logic [31:0] moment_one_out,
    output logic [31:0] moment_two_out,
    output logic        saturated,
    // configuration writes
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    adwu_pkg::cfg_t   cfg_reg;
    adwu_pkg::front_t front;
    adwu_pkg::root_t  root;
    adwu_pkg::quot_t  quot;
    logic             adv;

    logic [adwu_pkg::Q_W-1:0]      q_cap;
    logic signed [adwu_pkg::WIDE_W-1:0] step, nw;
    logic        out_valid_reg;
    logic [31:0] weight_reg, weight_next, m1_reg, m2_reg;
    logic        sat_reg, sat_next;

    // pipeline moves whenever the output register is free or being drained
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grad_scale        <= adwu_pkg::GRAD_SCALE_RST;
            cfg_reg.beta_first        <= adwu_pkg::BETA_FIRST_RST;
            cfg_reg.beta_second       <= adwu_pkg::BETA_SECOND_RST;
            cfg_reg.first_correction  <= adwu_pkg::FIRST_CORR_RST;
            cfg_reg.second_correction <= adwu_pkg::SECOND_CORR_RST;
            cfg_reg.learn_rate        <= adwu_pkg::LEARN_RATE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                adwu_pkg::CFG_GRAD_SCALE:  cfg_reg.grad_scale        <= cfg_data[16:0];
                adwu_pkg::CFG_BETA_FIRST:  cfg_reg.beta_first        <= cfg_data[15:0];
                adwu_pkg::CFG_BETA_SECOND: cfg_reg.beta_second       <= cfg_data[15:0];
                adwu_pkg::CFG_FIRST_CORR:  cfg_reg.first_correction  <= cfg_data;
                adwu_pkg::CFG_SECOND_CORR: cfg_reg.second_correction <= cfg_data;
                adwu_pkg::CFG_LEARN_RATE:  cfg_reg.learn_rate        <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    adwu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .weight_in     (weight_in),
        .gradient      (gradient),
        .moment_one_in (moment_one_in),
        .moment_two_in (moment_two_in),
        .front         (front)
    );

    adwu_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .front (front),
        .root  (root)
    );

    adwu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .root  (root),
        .quot  (quot)
    );

    // cap the step, apply it and clip the new weight
    always_comb
    begin
        if (quot.over || (quot.q[adwu_pkg::Q_W-1] && |quot.q[adwu_pkg::Q_W-2:0]))
            q_cap = adwu_pkg::STEP_CAP;
        else
            q_cap = quot.q;
        step        = $signed({{(adwu_pkg::WIDE_W-adwu_pkg::Q_W){1'b0}}, q_cap});
        nw          = $signed({{(adwu_pkg::WIDE_W-32){quot.c.w[31]}}, quot.c.w})
                    - (quot.c.neg ? -step : step);
        weight_next = adwu_pkg::sat_val(nw);
        sat_next    = quot.c.flag | adwu_pkg::sat_hit(nw);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= quot.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            weight_reg <= weight_next;
            m1_reg     <= quot.c.mm;
            m2_reg     <= quot.c.vv;
            sat_reg    <= sat_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign weight_out     = weight_reg;
    assign moment_one_out = m1_reg;
    assign moment_two_out = m2_reg;
    assign saturated      = sat_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench for adam_weight_update_unit, with its own Adam step predictor
// depends on adwu_pkg and adam_weight_update_unit

module tb_top;

    // result of one weight update
    typedef struct {
        logic [31:0] weight;
        logic [31:0] first_mom;
        logic [31:0] second_mom;
        logic        clipped;
    } update_t;

    // one row of the directed stimulus
    typedef struct {
        logic [31:0] weight;
        logic [31:0] grad;
        logic [31:0] first_mom;
        logic [31:0] second_mom;
        bit          typed;
        update_t     result;
    } stim_row_t;

    localparam logic [2:0] CFG_UNUSED    = 3'd6;
    localparam longint     EPSILON       = 3;      // 1e-8 in Q4.28
    localparam longint     STEP_LIMIT    = 64'd1 << 40;
    localparam int         SETTLE_CYCLES = 100;    // enough to flush the whole pipeline
    localparam int         RANDOM_ITEMS  = 350;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] weight_in;
    logic [31:0] gradient;
    logic [31:0] moment_one_in;
    logic [31:0] moment_two_in;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] weight_out;
    logic [31:0] moment_one_out;
    logic [31:0] moment_two_out;
    logic        saturated;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [19:0] cfg_data;

    // predictor copy of the configuration
    longint clip_scale;
    longint decay_first;
    longint decay_second;
    longint bias_first;
    longint bias_second;
    longint step_rate;

    update_t pending_updates[$];
    int      mismatches;
    bit      quiet;
    int      hold_requests;

    adam_weight_update_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .weight_in      (weight_in),
        .gradient       (gradient),
        .moment_one_in  (moment_one_in),
        .moment_two_in  (moment_two_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .weight_out     (weight_out),
        .moment_one_out (moment_one_out),
        .moment_two_out (moment_two_out),
        .saturated      (saturated),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2ms;
        $display("Verification failed");
        $finish;
    end

    // clip to the Q4.28 range and note it
    function automatic longint clip_value(input longint x, inout bit hit);
        if (x > 64'sd2147483647)
        begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            hit = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // bitwise integer square root
    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // expected outcome of one Adam step
    function automatic update_t adam_step(input logic [31:0] wi, input logic [31:0] gi,
                                          input logic [31:0] mi, input logic [31:0] vi);
        update_t     res;
        bit          hit;
        longint      g;
        longint      sq;
        longint      mm;
        longint      vv;
        longint      mhat;
        longint      vhat;
        longint      step;
        longint      nw;
        logic [63:0] gsq;
        logic [63:0] den;
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] q;
        hit  = 1'b0;
        g    = clip_value((longint'($signed(gi)) * clip_scale + 32768) >>> 16, hit);
        gsq  = g * g;
        sq   = clip_value(longint'((gsq + (64'd1 << 27)) >> 28), hit);
        mm   = clip_value((decay_first * longint'($signed(mi))
                          + (65536 - decay_first) * g + 32768) >>> 16, hit);
        vv   = clip_value((decay_second * longint'($signed(vi))
                          + (65536 - decay_second) * sq + 32768) >>> 16, hit);
        mhat = (mm * bias_first + 32768) >>> 16;
        vhat = (vv * bias_second + 32768) >>> 16;
        // negative second moment estimate counts as zero
        if (vhat < 0)
            vhat = 0;
        den  = int_sqrt(64'(vhat) << 28) + EPSILON;
        mag  = (mhat < 0) ? 64'(-mhat) : 64'(mhat);
        num  = (64'(step_rate) * mag) << 12;
        q    = (num + den / 2) / den;
        if (q > STEP_LIMIT)
            q = STEP_LIMIT;
        step = (mhat < 0) ? -longint'(q) : longint'(q);
        nw   = clip_value(longint'($signed(wi)) - step, hit);
        res.weight     = nw[31:0];
        res.first_mom  = mm[31:0];
        res.second_mom = vv[31:0];
        res.clipped    = hit;
        return res;
    endfunction

    // random field value, biased toward useful magnitudes
    function automatic logic [31:0] pick_value(input bit non_negative);
        logic [31:0] x;
        case ($urandom_range(0, 4))
            0:       x = $urandom;
            1:       x = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2:       x = $urandom_range(0, 32'h0FFF_FFFF);
            3:       x = $urandom_range(0, 32'h00FF_FFFF);
            default: x = $urandom_range(0, 32'h01FF_FFFF);
        endcase
        if (!non_negative && $urandom_range(0, 1))
            x = -x;
        return x;
    endfunction

    // result checking
    always @(posedge clk)
    begin
        update_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_updates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: weight %h", weight_out);
            end
            else
            begin
                want = pending_updates.pop_front();
                if (want.weight !== weight_out || want.first_mom !== moment_one_out
                    || want.second_mom !== moment_two_out || want.clipped !== saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                                 want.weight, want.first_mom, want.second_mom, want.clipped,
                                 weight_out, moment_one_out, moment_two_out, saturated);
                end
            end
        end
    end

    // output stall: random bursts plus a long hold on request
    always @(posedge clk)
    begin
        int run_left;
        int hold_left;
        int holds_seen;
        if (hold_requests != holds_seen)
        begin
            holds_seen = hold_requests;
            hold_left  = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (run_left > 0)
        begin
            run_left--;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            run_left = $urandom_range(0, 9);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // offer one transaction and record its expected update
    task automatic send_update(input logic [31:0] w, input logic [31:0] g,
                               input logic [31:0] m1, input logic [31:0] m2,
                               input bit typed, input update_t known);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        weight_in     <= w;
        gradient      <= g;
        moment_one_in <= m1;
        moment_two_in <= m2;
        do
            @(posedge clk);
        while (in_stall);
        pending_updates.push_back(typed ? known : adam_step(w, g, m1, m2));
    endtask

    // let every expected update come back, then let the pipeline empty
    task automatic drain_updates();
        in_valid <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // load all registers, then lower the enable
    task automatic load_config(input longint gs, input longint b1, input longint b2,
                               input longint c1, input longint c2, input longint lr);
        cfg_write <= 1'b1;
        cfg_index <= adwu_pkg::CFG_GRAD_SCALE;  cfg_data <= 20'(gs); @(posedge clk);
        cfg_index <= adwu_pkg::CFG_BETA_FIRST;  cfg_data <= 20'(b1); @(posedge clk);
        cfg_index <= adwu_pkg::CFG_BETA_SECOND; cfg_data <= 20'(b2); @(posedge clk);
        cfg_index <= adwu_pkg::CFG_FIRST_CORR;  cfg_data <= 20'(c1); @(posedge clk);
        cfg_index <= adwu_pkg::CFG_SECOND_CORR; cfg_data <= 20'(c2); @(posedge clk);
        cfg_index <= adwu_pkg::CFG_LEARN_RATE;  cfg_data <= 20'(lr); @(posedge clk);
        // unknown index must leave everything alone
        cfg_index <= CFG_UNUSED;      cfg_data <= 20'hFFFFF; @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        clip_scale   = gs;
        decay_first  = b1;
        decay_second = b2;
        bias_first   = c1;
        bias_second  = c2;
        step_rate    = lr;
    endtask

    // random phase of weight updates
    task automatic random_updates(input int count, input bit with_hold, input bit with_pause);
        update_t none;
        none = '{default: '0};
        for (int i = 0; i < count; i++)
        begin
            if (with_hold && i == 20)
                hold_requests++;
            if (with_pause && i == count / 2)
                drain_updates();
            send_update(pick_value(0), pick_value(0), pick_value(0),
                        pick_value($urandom_range(0, 3) != 0), 0, none);
        end
        drain_updates();
    endtask

    // stimulus
    initial
    begin
        stim_row_t rows[$];
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        weight_in     = '0;
        gradient      = '0;
        moment_one_in = '0;
        moment_two_in = '0;
        cfg_write     = 1'b0;
        cfg_index     = adwu_pkg::CFG_GRAD_SCALE;
        cfg_data      = '0;
        quiet         = 1'b0;
        hold_requests = 0;
        mismatches    = 0;
        clip_scale    = adwu_pkg::GRAD_SCALE_RST;
        decay_first   = adwu_pkg::BETA_FIRST_RST;
        decay_second  = adwu_pkg::BETA_SECOND_RST;
        bias_first    = adwu_pkg::FIRST_CORR_RST;
        bias_second   = adwu_pkg::SECOND_CORR_RST;
        step_rate     = adwu_pkg::LEARN_RATE_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under reset configuration; zero gradient and moments leave the weight
        rows.push_back('{32'h0000_0000, 0, 0, 0, 1, '{32'h0000_0000, 0, 0, 0}});
        rows.push_back('{32'h7FFF_FFFF, 0, 0, 0, 1, '{32'h7FFF_FFFF, 0, 0, 0}});
        rows.push_back('{32'h8000_0000, 0, 0, 0, 1, '{32'h8000_0000, 0, 0, 0}});
        rows.push_back('{32'h1000_0000, 32'h1000_0000, 0, 0, 0, '{default: '0}});
        rows.push_back('{32'h1000_0000, 32'hF000_0000, 0, 0, 0, '{default: '0}});
        rows.push_back('{0, 32'h7FFF_FFFF, 0, 0, 0, '{default: '0}});
        rows.push_back('{0, 32'h8000_0000, 0, 0, 0, '{default: '0}});
        rows.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                         '{default: '0}});
        rows.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
                         '{default: '0}});
        // negative second moment, clamped before the root
        rows.push_back('{0, 32'h0010_0000, 32'h0100_0000, 32'h8000_0000, 0, '{default: '0}});
        rows.push_back('{0, 0, 32'h0100_0000, 32'hFFFF_FFFF, 0, '{default: '0}});
        // large first moment over a zero second moment: root near zero, step at its cap
        rows.push_back('{0, 0, 32'h7FFF_FFFF, 0, 0, '{default: '0}});
        rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
                         '{default: '0}});
        rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h2AAA_AAAA, 0,
                         '{default: '0}});
        foreach (rows[i])
            send_update(rows[i].weight, rows[i].grad, rows[i].first_mom, rows[i].second_mom,
                        rows[i].typed, rows[i].result);
        drain_updates();

        random_updates(RANDOM_ITEMS, 1, 0);

        // lowest settings
        load_config(0, 0, 0, 65536, 65536, 0);
        random_updates(RANDOM_ITEMS, 0, 1);

        // highest settings, beyond the nominal range where the width allows
        load_config(131071, 65535, 65535, 1048575, 1048575, 65535);
        random_updates(RANDOM_ITEMS, 0, 0);

        load_config($urandom_range(0, 65536), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(65536, 1048575),
                    $urandom_range(65536, 1048575), $urandom_range(0, 65535));
        random_updates(RANDOM_ITEMS, 0, 0);

        load_config(adwu_pkg::GRAD_SCALE_RST, adwu_pkg::BETA_FIRST_RST,
                    adwu_pkg::BETA_SECOND_RST, adwu_pkg::FIRST_CORR_RST,
                    adwu_pkg::SECOND_CORR_RST, adwu_pkg::LEARN_RATE_RST);
        random_updates(RANDOM_ITEMS / 2, 0, 0);

        // closing stretch at full rate
        quiet = 1'b1;
        random_updates(RANDOM_ITEMS, 0, 0);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
